// ----- hw/rtl/rejected_flow_record_table_top_assert.svh -----
// assertion macros used by rfrt_datapath
`ifndef REJECTED_FLOW_RECORD_TABLE_TOP_ASSERT_SVH
`define REJECTED_FLOW_RECORD_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RFRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfrt assertion failed");

// next-cycle implication, checked out of reset
`define RFRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfrt assertion failed");

`endif

// ----- hw/rtl/rfrt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rfrt_pkg;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OUTCOME_UPDATED  = 2'd0,
    OUTCOME_INSERTED = 2'd1,
    OUTCOME_FULL     = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] count;
    logic [15:0] tag;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture word, read slot zero
    logic advance;  // step to the next slot
    logic latch;    // scan ends, keep hit / insert decision
    logic commit;   // load result register, write slot unless full
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic empty;
    logic last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rfrt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rfrt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] urgent_tag;

  modport source (
    output valid, source_address, dest_address, source_port, dest_port, urgent_tag,
    input  ready
  );
  modport sink (
    input  valid, source_address, dest_address, source_port, dest_port, urgent_tag,
    output ready
  );
endinterface

interface rfrt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [3:0]  slot_index;
  logic [31:0] hit_count;
  logic [15:0] kept_tag;
  logic        report_now;

  modport source (
    output valid, outcome, slot_index, hit_count, kept_tag, report_now,
    input  ready
  );
  modport sink (
    input  valid, outcome, slot_index, hit_count, kept_tag, report_now,
    output ready
  );
endinterface
`default_nettype wire

// ----- hw/rtl/rfrt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rfrt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rfrt_pkg::status_t status,
  output rfrt_pkg::cmd_t        cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   found;

  assign found    = status.hit | status.empty;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.load    = in_ready & in_valid;
    cmd.advance = (state_r == ST_SCAN) & ~found & ~status.last;
    cmd.latch   = (state_r == ST_SCAN) & (found | status.last);
    cmd.commit  = (state_r == ST_COMMIT) & status.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (cmd.load) state_nxt = ST_SCAN;
      ST_SCAN:   if (cmd.latch) state_nxt = ST_COMMIT;
      ST_COMMIT: if (cmd.commit) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rfrt_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "rejected_flow_record_table_top_assert.svh"
module rfrt_datapath #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rfrt_pkg::cmd_t cmd,
  output rfrt_pkg::status_t  status,
  input  wire logic [31:0]   in_source_address,
  input  wire logic [31:0]   in_dest_address,
  input  wire logic [15:0]   in_source_port,
  input  wire logic [15:0]   in_dest_port,
  input  wire logic [15:0]   in_urgent_tag,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_outcome,
  output logic [3:0]         out_slot_index,
  output logic [31:0]        out_hit_count,
  output logic [15:0]        out_kept_tag,
  output logic               out_report_now
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  rfrt_pkg::entry_t mem [TABLE_ENTRIES];
  rfrt_pkg::entry_t rd_data_r;
  rfrt_pkg::entry_t stored;
  rfrt_pkg::entry_t new_entry;
  logic             rd_valid_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [IDX_W-1:0]         chk_idx_r;
  logic                     hit_r;
  logic                     ins_r;
  logic                     do_write;

  logic [31:0] key_src_r;
  logic [31:0] key_dst_r;
  logic [15:0] key_sp_r;
  logic [15:0] key_dp_r;
  logic [15:0] key_tag_r;

  logic [31:0] new_count;
  logic [15:0] new_tag;
  logic [IDX_W+3:0] slot_ext;

  logic        out_valid_r;
  rfrt_pkg::outcome_t out_outcome_r;
  logic [3:0]  out_slot_r;
  logic [31:0] out_count_r;
  logic [15:0] out_tag_r;
  logic        out_report_r;

  // key capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_src_r <= in_source_address;
      key_dst_r <= in_dest_address;
      key_sp_r  <= in_source_port;
      key_dp_r  <= in_dest_port;
      key_tag_r <= in_urgent_tag;
    end
  end

  // scan pointer and decision
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_idx_r <= '0;
      hit_r     <= 1'b0;
      ins_r     <= 1'b0;
    end else begin
      if (cmd.load) begin
        chk_idx_r <= '0;
      end else if (cmd.advance) begin
        chk_idx_r <= chk_idx_r + 1'b1;
      end
      if (cmd.latch) begin
        hit_r <= status.hit;
        ins_r <= ~status.hit & status.empty;
      end
    end
  end

  assign rd_en    = cmd.load | cmd.advance;
  assign rd_addr  = cmd.load ? '0 : chk_idx_r + 1'b1;
  assign do_write = cmd.commit & (hit_r | ins_r);

  // table memory, one read and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
    if (do_write) begin
      mem[chk_idx_r] <= new_entry;
    end
  end

  // a never written slot reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (do_write) begin
      valid_r[chk_idx_r] <= 1'b1;
    end
  end

  assign stored = rd_valid_r ? rd_data_r : '0;

  always_comb begin
    status          = '0;
    status.hit      = (stored.src_addr == key_src_r) && (stored.dst_addr == key_dst_r) &&
                      (stored.src_port == key_sp_r) && (stored.dst_port == key_dp_r);
    status.empty    = (stored.src_addr == 32'd0);
    status.last     = (chk_idx_r == LAST_IDX);
    status.out_free = ~out_valid_r | out_ready;
  end

  always_comb begin
    new_count = (stored.count != rfrt_pkg::COUNT_MAX) ? stored.count + 32'd1 : stored.count;
    new_tag   = ((key_tag_r != 16'd0) || (stored.tag == 16'd0)) ? key_tag_r : stored.tag;
    new_entry.src_addr = key_src_r;
    new_entry.dst_addr = key_dst_r;
    new_entry.src_port = key_sp_r;
    new_entry.dst_port = key_dp_r;
    new_entry.count    = hit_r ? new_count : 32'd1;
    new_entry.tag      = hit_r ? new_tag : key_tag_r;
  end

  assign slot_ext = {4'd0, chk_idx_r};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (hit_r | ins_r) begin
        out_outcome_r <= hit_r ? rfrt_pkg::OUTCOME_UPDATED : rfrt_pkg::OUTCOME_INSERTED;
        out_slot_r    <= slot_ext[3:0];
        out_count_r   <= new_entry.count;
        out_tag_r     <= new_entry.tag;
        out_report_r  <= 1'b1;
      end else begin
        out_outcome_r <= rfrt_pkg::OUTCOME_FULL;
        out_slot_r    <= 4'd0;
        out_count_r   <= 32'd0;
        out_tag_r     <= 16'd0;
        out_report_r  <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_outcome    = out_outcome_r;
  assign out_slot_index = out_slot_r;
  assign out_hit_count  = out_count_r;
  assign out_kept_tag   = out_tag_r;
  assign out_report_now = out_report_r;

  `RFRT_ASSERT_NEXT(a_full_leaves_table, cmd.commit && !hit_r && !ins_r, $stable(valid_r))
  `RFRT_ASSERT_NOW(a_commit_needs_free_out, cmd.commit, !out_valid_r || out_ready)
  `RFRT_ASSERT_NEXT(a_insert_counts_one, cmd.commit && ins_r, out_count_r == 32'd1)
  `RFRT_ASSERT_NOW(a_no_read_on_commit, cmd.commit || cmd.latch, !rd_en)

endmodule
`default_nettype wire

// ----- hw/rtl/rejected_flow_record_table_top.sv -----
// word to result: load, a SCAN step per slot (1 to TABLE_ENTRIES), COMMIT when output free
// one word at a time: the next word is taken only once the previous one is committed
// the scan reads one table slot per cycle from a single-read-port memory
// a new word is taken while the previous result still waits in the output register
// reset: synchronous, active low; per-slot valid bits clear at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module rejected_flow_record_table_top #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rfrt_in_if.sink     in_chan,
  rfrt_out_if.source  out_chan
);

  rfrt_pkg::cmd_t    cmd;
  rfrt_pkg::status_t status;
  logic              in_ready;

  assign in_chan.ready = in_ready;

  rfrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rfrt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_source_address (in_chan.source_address),
    .in_dest_address   (in_chan.dest_address),
    .in_source_port    (in_chan.source_port),
    .in_dest_port      (in_chan.dest_port),
    .in_urgent_tag     (in_chan.urgent_tag),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_outcome       (out_chan.outcome),
    .out_slot_index    (out_chan.slot_index),
    .out_hit_count     (out_chan.hit_count),
    .out_kept_tag      (out_chan.kept_tag),
    .out_report_now    (out_chan.report_now)
  );

endmodule
`default_nettype wire
